/* rtl/lr35902_alu_flag_unit_defines.svh */
// ---------------------------------------------------------------------------
// LR35902 ALU and flag unit: assertion macros
// Shared macros for the concurrent checks on the unit's ports.
// ---------------------------------------------------------------------------
`ifndef LR35902_ALU_FLAG_UNIT_DEFINES_SVH
`define LR35902_ALU_FLAG_UNIT_DEFINES_SVH

// An implication that is checked only outside reset.
`define LR_CHK_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// A property that must hold in the cycle after reset is seen.
`define LR_CHK_AFTER_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error(msg);

// A stalled transfer keeps its signal unchanged into the next cycle.
`define LR_CHK_HOLD(lbl, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) \
    ((vld) && !(rdy)) |=> $stable(sig)) \
    else $error(msg);

`endif

/* rtl/lr35902_pkg.sv */
// ---------------------------------------------------------------------------
// LR35902 package
// Operation codes, flag layout and the result bundle of the execute unit.
// ---------------------------------------------------------------------------
`default_nettype none

package lr35902_pkg;

  localparam int unsigned FuncW = 5;
  localparam int unsigned DataW = 16;
  localparam int unsigned FlagW = 4;

  typedef enum logic [FuncW-1:0] {
    FN_ADD   = 5'd0,
    FN_ADC   = 5'd1,
    FN_SUB   = 5'd2,
    FN_SBC   = 5'd3,
    FN_AND   = 5'd4,
    FN_XOR   = 5'd5,
    FN_OR    = 5'd6,
    FN_CP    = 5'd7,
    FN_INC   = 5'd8,
    FN_DEC   = 5'd9,
    FN_RLC   = 5'd10,
    FN_RRC   = 5'd11,
    FN_RL    = 5'd12,
    FN_RR    = 5'd13,
    FN_SLA   = 5'd14,
    FN_SRA   = 5'd15,
    FN_SWAP  = 5'd16,
    FN_SRL   = 5'd17,
    FN_BIT   = 5'd18,
    FN_RES   = 5'd19,
    FN_SET   = 5'd20,
    FN_RLCA  = 5'd21,
    FN_RRCA  = 5'd22,
    FN_RLA   = 5'd23,
    FN_RRA   = 5'd24,
    FN_CPL   = 5'd25,
    FN_SCF   = 5'd26,
    FN_CCF   = 5'd27,
    FN_ADD16 = 5'd28
  } func_t;

  // Flags in the order Z N H C, from bit 3 down to bit 0.
  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  typedef struct packed {
    logic [DataW-1:0] value;
    flags_t           flags;
    logic             wb;
  } exec_res_t;

endpackage

`default_nettype wire

/* rtl/lr35902_exec.sv */
// ---------------------------------------------------------------------------
// LR35902 execute logic
// Combinational result, flag and write-back computation for one operation.
// ---------------------------------------------------------------------------
`default_nettype none

module lr35902_exec (
  input  wire logic [lr35902_pkg::FuncW-1:0] func,
  input  wire logic [lr35902_pkg::DataW-1:0] first_operand,
  input  wire logic [lr35902_pkg::DataW-1:0] second_operand,
  input  wire logic [2:0]                    bit_index,
  input  wire lr35902_pkg::flags_t           flags_in,
  output lr35902_pkg::exec_res_t             res
);
  import lr35902_pkg::*;

  logic [7:0]  a;
  logic [7:0]  v;
  logic        cin;
  logic        use_c;
  logic [8:0]  sum9;
  logic [4:0]  sum_lo;
  logic [8:0]  dif9;
  logic [4:0]  dif_lo;
  logic [16:0] sum17;
  logic [12:0] sum13;
  logic [7:0]  inc8;
  logic [7:0]  dec8;
  logic [7:0]  bmask;
  logic [7:0]  r8;

  assign a     = first_operand[7:0];
  assign v     = second_operand[7:0];
  assign cin   = flags_in.c;
  assign use_c = cin && (func == FN_ADC || func == FN_SBC);

  assign sum9   = {1'b0, a} + {1'b0, v} + {8'd0, use_c};
  assign sum_lo = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, use_c};
  assign dif9   = {1'b0, a} - {1'b0, v} - {8'd0, use_c};
  assign dif_lo = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, use_c};
  assign sum17  = {1'b0, first_operand} + {1'b0, second_operand};
  assign sum13  = {1'b0, first_operand[11:0]} + {1'b0, second_operand[11:0]};
  assign inc8   = a + 8'd1;
  assign dec8   = a - 8'd1;
  assign bmask  = 8'd1 << bit_index;

  always_comb begin
    r8        = 8'd0;
    res.value = '0;
    res.flags = flags_in;
    res.wb    = 1'b1;
    case (func)
      FN_ADD, FN_ADC: begin
        r8        = sum9[7:0];
        res.flags = '{z: (r8 == 8'd0), n: 1'b0, h: sum_lo[4], c: sum9[8]};
      end
      FN_SUB, FN_SBC, FN_CP: begin
        r8        = dif9[7:0];
        res.flags = '{z: (r8 == 8'd0), n: 1'b1, h: dif_lo[4], c: dif9[8]};
        res.wb    = (func != FN_CP);
      end
      FN_AND, FN_XOR, FN_OR: begin
        if (func == FN_AND) begin
          r8 = a & v;
        end else if (func == FN_XOR) begin
          r8 = a ^ v;
        end else begin
          r8 = a | v;
        end
        res.flags = '{z: (r8 == 8'd0), n: 1'b0, h: (func == FN_AND), c: 1'b0};
      end
      FN_INC: begin
        r8        = inc8;
        res.flags = '{z: (r8 == 8'd0), n: 1'b0, h: (a[3:0] == 4'hF), c: cin};
      end
      FN_DEC: begin
        r8        = dec8;
        res.flags = '{z: (r8 == 8'd0), n: 1'b1, h: (a[3:0] == 4'h0), c: cin};
      end
      FN_RLC, FN_RRC, FN_RL, FN_RR, FN_SLA, FN_SRA, FN_SWAP, FN_SRL: begin
        res.flags.c = 1'b0;
        case (func)
          FN_RLC:  begin r8 = {a[6:0], a[7]}; res.flags.c = a[7]; end
          FN_RRC:  begin r8 = {a[0], a[7:1]}; res.flags.c = a[0]; end
          FN_RL:   begin r8 = {a[6:0], cin};  res.flags.c = a[7]; end
          FN_RR:   begin r8 = {cin, a[7:1]};  res.flags.c = a[0]; end
          FN_SLA:  begin r8 = {a[6:0], 1'b0}; res.flags.c = a[7]; end
          FN_SRA:  begin r8 = {a[7], a[7:1]}; res.flags.c = a[0]; end
          FN_SWAP: begin r8 = {a[3:0], a[7:4]}; end
          default: begin r8 = {1'b0, a[7:1]}; res.flags.c = a[0]; end
        endcase
        res.flags.z = (r8 == 8'd0);
        res.flags.n = 1'b0;
        res.flags.h = 1'b0;
      end
      FN_BIT: begin
        r8        = a;
        res.wb    = 1'b0;
        res.flags = '{z: ~a[bit_index], n: 1'b0, h: 1'b1, c: cin};
      end
      FN_RES: begin
        r8 = a & ~bmask;
      end
      FN_SET: begin
        r8 = a | bmask;
      end
      FN_RLCA, FN_RRCA, FN_RLA, FN_RRA: begin
        res.flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: 1'b0};
        case (func)
          FN_RLCA: begin r8 = {a[6:0], a[7]}; res.flags.c = a[7]; end
          FN_RRCA: begin r8 = {a[0], a[7:1]}; res.flags.c = a[0]; end
          FN_RLA:  begin r8 = {a[6:0], cin};  res.flags.c = a[7]; end
          default: begin r8 = {cin, a[7:1]};  res.flags.c = a[0]; end
        endcase
      end
      FN_CPL: begin
        r8          = ~a;
        res.flags.n = 1'b1;
        res.flags.h = 1'b1;
      end
      FN_SCF: begin
        r8        = a;
        res.wb    = 1'b0;
        res.flags = '{z: flags_in.z, n: 1'b0, h: 1'b0, c: 1'b1};
      end
      FN_CCF: begin
        r8        = a;
        res.wb    = 1'b0;
        res.flags = '{z: flags_in.z, n: 1'b0, h: 1'b0, c: ~cin};
      end
      FN_ADD16: begin
        res.flags = '{z: flags_in.z, n: 1'b0, h: sum13[12], c: sum17[16]};
      end
      default: begin
        res.wb = 1'b0;
      end
    endcase
    if (func == FN_ADD16) begin
      res.value = sum17[15:0];
    end else begin
      res.value = {8'd0, r8};
    end
  end

endmodule

`default_nettype wire

/* rtl/lr35902_alu_flag_unit.sv */
// ---------------------------------------------------------------------------
// LR35902 ALU and flag unit
// Execute stage with ALU, CB shifts, bit operations and flag generation.
// ---------------------------------------------------------------------------
// The unit takes one operation per clock cycle while out_ready does not hold
// the output back, and returns exactly one result for each, in order. An
// accepted operation is captured in an input register, evaluated by a single
// level of shallow combinational logic, and captured in a result register;
// those two registers work as a two-entry pipeline. While a finished result
// waits, the input side accepts only into an empty input register: a stage
// advances whenever the stage after it is empty or is being emptied in the
// same cycle. The unit holds no architectural state; reset only empties the
// pipeline.
`default_nettype none

module lr35902_alu_flag_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [lr35902_pkg::FuncW-1:0] func,
  input  wire logic [lr35902_pkg::DataW-1:0] first_operand,
  input  wire logic [lr35902_pkg::DataW-1:0] second_operand,
  input  wire logic [2:0]                    bit_index,
  input  wire logic [lr35902_pkg::FlagW-1:0] flags_in,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [lr35902_pkg::DataW-1:0]      result_value,
  output logic [lr35902_pkg::FlagW-1:0]      flags_out,
  output logic                               write_back
);
  import lr35902_pkg::*;

  // Input register.
  logic             in_full;
  logic [FuncW-1:0] func_q;
  logic [DataW-1:0] op1_q;
  logic [DataW-1:0] op2_q;
  logic [2:0]       bidx_q;
  flags_t           flags_q;

  // Result register.
  exec_res_t        res_next;
  exec_res_t        res_q;

  logic             res_load;

  // The result register can load when it is empty or its transfer completes.
  assign res_load = !out_valid || out_ready;
  // The input register can load when it is empty or moves on this cycle.
  assign in_ready = !in_full || res_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_q  <= func;
      op1_q   <= first_operand;
      op2_q   <= second_operand;
      bidx_q  <= bit_index;
      flags_q <= flags_t'(flags_in);
    end
  end

  lr35902_exec u_exec (
    .func           (func_q),
    .first_operand  (op1_q),
    .second_operand (op2_q),
    .bit_index      (bidx_q),
    .flags_in       (flags_q),
    .res            (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load && in_full) begin
      res_q <= res_next;
    end
  end

  assign result_value = res_q.value;
  assign flags_out    = res_q.flags;
  assign write_back   = res_q.wb;

endmodule

`default_nettype wire

/* rtl/lr35902_chk.sv */
// ---------------------------------------------------------------------------
// LR35902 ALU and flag unit checker
// Port-level checks on the execute unit, attached to the top level by bind.
// ---------------------------------------------------------------------------
`default_nettype none

`include "lr35902_alu_flag_unit_defines.svh"

module lr35902_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] result_value,
  input wire logic [3:0]  flags_out,
  input wire logic        write_back
);

  `LR_CHK_AFTER_RST(a_empty_after_rst, !out_valid, "result valid right after reset")
  `LR_CHK_IMPL(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")
  `LR_CHK_IMPL(a_wide_result_written, out_valid && (result_value[15:8] != 8'd0), write_back,
               "wide result not marked for write-back")
  `LR_CHK_HOLD(a_valid_hold, out_valid, out_ready, out_valid, "result valid dropped")
  `LR_CHK_HOLD(a_result_hold, out_valid, out_ready, {result_value, flags_out, write_back},
               "result changed while stalled")

endmodule

bind lr35902_alu_flag_unit lr35902_chk u_lr35902_chk (.*);

`default_nettype wire
